// ===== design/decimal_digit_pattern_count_core_defines.svh =====
// Assertion macros for the digit pattern counter.
`ifndef DECIMAL_DIGIT_PATTERN_COUNT_CORE_DEFINES_SVH
`define DECIMAL_DIGIT_PATTERN_COUNT_CORE_DEFINES_SVH

`ifndef SYNTH
// checked outside reset
`define DDPC_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define DDPC_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DDPC_ASSERT(name, clk, rst, prop, msg)
`define DDPC_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ===== design/ddpc_pkg.sv =====
package ddpc_pkg;

  localparam int IN_W       = 31;
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int LEN_W      = $clog2(NUM_DIGITS + 1);
  localparam int BIT_CNT_W  = $clog2(IN_W);
  localparam int CNT_W      = 4;
  localparam int S_DATA_W   = ((2 * IN_W + 7) / 8) * 8;
  localparam int M_DATA_W   = ((CNT_W + 7) / 8) * 8;

  typedef logic [BCD_W-1:0] bcd_t;
  typedef logic [LEN_W-1:0] len_t;

  // one double-dabble step: add 3 to digits of 5 or more, then shift in a bit
  function automatic bcd_t dabble(input bcd_t bcd, input logic bit_in);
    bcd_t adj;
    adj = bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

  // number of significant digits, at least one
  function automatic len_t digit_len(input bcd_t bcd);
    len_t len;
    len = len_t'(1);
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
        len = len_t'(i + 1);
      end
    end
    return len;
  endfunction

endpackage

// ===== design/decimal_digit_pattern_count_core.sv =====
// Each input transaction runs through bit-serial BCD conversion, one length step, one match
//   step per window of the search in the base (none when the search does not fit), and an
//   output load, which waits for m_tready while an earlier count is still held.
// One input at a time: s_tready is high only in idle; the bit-serial BCD conversion sets the pace.
// A result held on m_tdata does not block the next input transaction.
// Reset (rst, synchronous, active high) returns the control to idle and drops m_tvalid.
`include "decimal_digit_pattern_count_core_defines.svh"

module decimal_digit_pattern_count_core
  import ddpc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // [30:0] base_number, [61:31] search_number, [63:62] zero
  input  logic [S_DATA_W-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // [3:0] occurrence_count, [7:4] zero
  output logic [M_DATA_W-1:0] m_tdata
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CONV  = 5'b00010,
    ST_LEN   = 5'b00100,
    ST_MATCH = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t               state;
  logic [IN_W-1:0]      base_sh;   // binary, shifted out MSB first
  logic [IN_W-1:0]      srch_sh;
  bcd_t                 base_bcd;  // digit 0 is the units digit
  bcd_t                 srch_bcd;
  logic [BIT_CNT_W-1:0] bit_cnt;
  len_t                 base_len;
  len_t                 srch_len;
  len_t                 pos;       // start position being tested, units end
  len_t                 last_pos;
  logic [CNT_W-1:0]     count;

  // lengths, only meaningful in ST_LEN
  len_t base_len_c;
  len_t srch_len_c;
  logic hit;
  logic out_free;

  assign base_len_c = digit_len(base_bcd);
  assign srch_len_c = digit_len(srch_bcd);
  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == ST_IDLE);

  // pattern test at the current window: base is shifted down one digit per step,
  // so the window always sits in the low digits
  always_comb begin
    hit = 1'b1;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (len_t'(k) < srch_len &&
          base_bcd[k*DIGIT_W +: DIGIT_W] != srch_bcd[k*DIGIT_W +: DIGIT_W]) begin
        hit = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // a new count may replace one taken in the same cycle
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (bit_cnt == BIT_CNT_W'(IN_W - 1)) begin
            state <= ST_LEN;
          end
        end
        ST_LEN: begin
          // a search longer than the base never matches
          state <= (srch_len_c > base_len_c) ? ST_DONE : ST_MATCH;
        end
        ST_MATCH: begin
          if (pos == last_pos) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        base_sh  <= s_tdata[IN_W-1:0];
        srch_sh  <= s_tdata[2*IN_W-1:IN_W];
        base_bcd <= '0;
        srch_bcd <= '0;
        bit_cnt  <= '0;
        pos      <= '0;
        count    <= '0;
      end
      ST_CONV: begin
        base_bcd <= dabble(base_bcd, base_sh[IN_W-1]);
        srch_bcd <= dabble(srch_bcd, srch_sh[IN_W-1]);
        base_sh  <= {base_sh[IN_W-2:0], 1'b0};
        srch_sh  <= {srch_sh[IN_W-2:0], 1'b0};
        bit_cnt  <= bit_cnt + BIT_CNT_W'(1);
      end
      ST_LEN: begin
        base_len <= base_len_c;
        srch_len <= srch_len_c;
        last_pos <= base_len_c - srch_len_c;
      end
      ST_MATCH: begin
        count    <= count + CNT_W'(hit);
        base_bcd <= {DIGIT_W'(0), base_bcd[BCD_W-1:DIGIT_W]};
        pos      <= pos + len_t'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          m_tdata <= {{(M_DATA_W - CNT_W){1'b0}}, count};
        end
      end
      default: begin
      end
    endcase
  end

  // assertions
  `DDPC_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == ST_IDLE && !m_tvalid), "reset did not idle")
  `DDPC_ASSERT(a_accept_starts, clk, rst, (s_tvalid && s_tready) |=> (state == ST_CONV && bit_cnt == '0), "accept did not start conversion")
  `DDPC_ASSERT(a_window_fits, clk, rst, (state == ST_MATCH) |-> (pos <= last_pos && last_pos + srch_len == base_len), "match window beyond base digits")
  `DDPC_ASSERT(a_count_bound, clk, rst, (state == ST_MATCH) |-> (count <= CNT_W'(pos)), "count exceeds windows tested")
  `DDPC_ASSERT(a_out_range, clk, rst, m_tvalid |-> (m_tdata[CNT_W-1:0] <= CNT_W'(NUM_DIGITS)), "count out of range")

endmodule

// ===== dv/decimal_digit_pattern_count_core_test.sv =====
module decimal_digit_pattern_count_core_test;
  import ddpc_pkg::*;

  localparam int RANDOM_PAIRS = 780;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_WAIT   = 60;     // extra wait after the last count is back
  localparam int MAX_REPORTS  = 10;
  localparam logic [3:0] COUNT_SAT = 4'd15;

  // decimal digit string, most significant digit at index 0
  typedef struct packed {
    logic [3:0]                 len;
    logic [NUM_DIGITS-1:0][3:0] d;
  } digit_str_t;

  // one input pair plus how the sender treats it
  typedef struct {
    logic [IN_W-1:0] base;
    logic [IN_W-1:0] search;
    int              gap;    // idle cycles after this pair is taken
    bit              drain;  // hold this pair until every count is back
  } pair_t;

  typedef struct {
    logic [IN_W-1:0] base;
    logic [IN_W-1:0] search;
    logic [CNT_W-1:0] count;
  } count_exp_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  pair_t      pending_pairs[$];
  count_exp_t expected_counts[$];
  pair_t      cur_pair;
  int         gap_left = 0;
  int         stall_left = 0;
  int         fail_cnt = 0;
  int         cycle_cnt = 0;

  decimal_digit_pattern_count_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Digit-string predictor
  // ---------------------------------------------------------------------------

  // split a value into decimal digits, keeping at most NUM_DIGITS low digits
  function automatic digit_str_t to_digits(logic [IN_W-1:0] v);
    digit_str_t ds;
    int unsigned x;
    int unsigned t;
    int          n;
    ds = '0;
    x  = 32'(v);
    t  = x;
    n  = 1;
    while (t >= 10 && n < NUM_DIGITS) begin
      t = t / 10;
      n++;
    end
    for (int i = 0; i < n; i++) begin
      ds.d[n-1-i] = 4'(x % 10);
      x = x / 10;
    end
    ds.len = 4'(n);
    return ds;
  endfunction

  // overlapping occurrences of the search digits inside the base digits
  function automatic logic [CNT_W-1:0] count_occurrences(logic [IN_W-1:0] base,
                                                        logic [IN_W-1:0] search);
    digit_str_t bd;
    digit_str_t sd;
    logic [CNT_W-1:0] cnt;
    bit hit;
    bd  = to_digits(base);
    sd  = to_digits(search);
    cnt = '0;
    if (sd.len <= bd.len) begin
      for (int s = 0; s + sd.len <= bd.len; s++) begin
        hit = 1'b1;
        for (int k = 0; k < sd.len; k++) begin
          if (bd.d[s+k] != sd.d[k]) hit = 1'b0;
        end
        if (hit && cnt != COUNT_SAT) cnt++;
      end
    end
    return cnt;
  endfunction

  function automatic void note_failure(string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) $display("ERROR @%0d: %s", cycle_cnt, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // random n-digit number from digits lo..hi; ten-digit ones lead with 1 to fit 31 bits
  function automatic logic [IN_W-1:0] random_number(int n, int lo, int hi);
    longint v;
    int     dig;
    v = 0;
    for (int i = 0; i < n; i++) begin
      dig = $urandom_range(hi, lo);
      if (i == 0 && n > 1 && dig == 0) dig = hi;
      if (i == 0 && n == NUM_DIGITS && dig >= 2) dig = 1;
      v = v * 10 + dig;
    end
    return IN_W'(v);
  endfunction

  // a run of the base's own digits, so that at least one match exists
  function automatic logic [IN_W-1:0] digit_slice(logic [IN_W-1:0] base);
    digit_str_t ds;
    int         first;
    int         n;
    longint     v;
    ds    = to_digits(base);
    first = $urandom_range(ds.len - 1, 0);
    n     = $urandom_range(ds.len - first, 1);
    v     = 0;
    for (int i = 0; i < n; i++) v = v * 10 + ds.d[first+i];
    return IN_W'(v);
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(99, 0);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(4, 1);
    if (r < 97) return $urandom_range(20, 5);
    return $urandom_range(80, 21);
  endfunction

  function automatic void add_pair(logic [IN_W-1:0] base, logic [IN_W-1:0] search,
                                   int gap, bit drain);
    pair_t p;
    p.base   = base;
    p.search = search;
    p.gap    = gap;
    p.drain  = drain;
    pending_pairs.push_back(p);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one pair per transaction, held until s_tready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : send_pairs
    bit    busy;
    pair_t nxt;
    busy = s_tvalid;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      gap_left <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_counts.push_back('{cur_pair.base, cur_pair.search,
                                    count_occurrences(cur_pair.base, cur_pair.search)});
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending_pairs.size() != 0 &&
                     !(pending_pairs[0].drain && expected_counts.size() != 0)) begin
          nxt      = pending_pairs.pop_front();
          cur_pair <= nxt;
          s_tvalid <= 1'b1;
          s_tdata  <= S_DATA_W'({nxt.search, nxt.base});
          gap_left <= nxt.gap;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, check each count transaction in order
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : take_counts
    count_exp_t exp_cnt;
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_counts.size() == 0) begin
          note_failure($sformatf("count %0d with no pair outstanding",
                                 m_tdata[CNT_W-1:0]));
        end else begin
          exp_cnt = expected_counts.pop_front();
          if (m_tdata[CNT_W-1:0] !== exp_cnt.count)
            note_failure($sformatf("base %0d search %0d: count exp %0d got %0d",
                                   exp_cnt.base, exp_cnt.search, exp_cnt.count,
                                   m_tdata[CNT_W-1:0]));
        end
      end
      // bit 11 of the cycle counter opens long windows in which the sink starts no new stall
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        m_tready   <= 1'b0;
      end else if (!cycle_cnt[11] && $urandom_range(4, 0) == 0) begin
        m_tready   <= 1'b0;
        stall_left <= idle_len();
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("decimal_digit_pattern_count_core regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    logic [IN_W-1:0] b;
    logic [IN_W-1:0] s;
    int              r;
    int              lo;
    int              gap;

    // directed: zero, field extremes, overlap, the largest count,
    // search longer than base, zeros inside and at the end of the digits
    add_pair(0, 0, 0, 1'b0);
    add_pair(0, 1, 0, 1'b0);
    add_pair(1, 0, 0, 1'b0);
    add_pair(7, 7, 0, 1'b0);
    add_pair(31'h7FFF_FFFF, 7, 0, 1'b0);
    add_pair(31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 1'b0);
    add_pair(31'h7FFF_FFFF, 31'h7FFF_FFFE, 0, 1'b0);
    add_pair(31'h7FFF_FFFF, 0, 3, 1'b0);
    add_pair(0, 31'h7FFF_FFFF, 0, 1'b0);
    add_pair(5, 12, 0, 1'b0);
    add_pair(12, 1234, 0, 1'b0);
    add_pair(1, 1000000000, 0, 1'b0);
    add_pair(1111111111, 1, 0, 1'b0);
    add_pair(1111111111, 11, 0, 1'b0);
    add_pair(1111111111, 1111111111, 0, 1'b0);
    add_pair(1000000000, 0, 0, 1'b0);
    add_pair(1000000000, 1000000000, 0, 1'b0);
    add_pair(1000000000, 100, 5, 1'b0);
    add_pair(1212121212, 121, 0, 1'b0);
    add_pair(1212121212, 21, 0, 1'b0);
    add_pair(999999999, 99, 0, 1'b0);
    add_pair(123, 0, 0, 1'b0);
    add_pair(100, 100, 0, 1'b0);
    add_pair(31'h2AAA_AAAA, 31'h5555_5555, 0, 1'b0);

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      r = $urandom_range(99, 0);
      if (r < 40) begin
        // search taken from the base's digits
        b = random_number($urandom_range(NUM_DIGITS, 1), 0, 9);
        s = digit_slice(b);
      end else if (r < 60) begin
        // two-digit alphabet: many overlapping hits
        lo = $urandom_range(8, 0);
        b  = random_number($urandom_range(NUM_DIGITS, 5), lo, lo + 1);
        s  = random_number($urandom_range(3, 1), lo, lo + 1);
      end else if (r < 80) begin
        b = IN_W'($urandom_range(32'h7FFF_FFFF, 0));
        s = IN_W'($urandom_range(32'h7FFF_FFFF, 0));
      end else if (r < 90) begin
        b = random_number($urandom_range(NUM_DIGITS, 1), 0, 9);
        s = random_number($urandom_range(NUM_DIGITS, 1), 0, 9);
      end else begin
        b = IN_W'($urandom_range(32'h7FFF_FFFF, 0));
        s = IN_W'($urandom_range(9, 0));
      end
      // every third block of 64 pairs runs back to back
      gap = ((i / 64) % 3 == 0) ? 0 : idle_len();
      // sender waits for the pipeline to empty now and then
      add_pair(b, s, gap, (i % 200) == 0);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_pairs.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("decimal_digit_pattern_count_core regression: pass");
    end else begin
      $display("decimal_digit_pattern_count_core regression: fail");
    end
    $finish;
  end

endmodule
